FILE: rtl/sscr_pkg.sv
// Shared types and constants of the stick square/circle remapper.
// Used by every module of the block; depends on nothing.
package sscr_pkg;

    // Ratio format: unsigned, eight integer bits and RATIO_FRAC_BITS fraction bits.
    localparam int RATIO_FRAC_BITS = 16;
    localparam int RATIO_W         = RATIO_FRAC_BITS + 8;
    localparam logic [RATIO_W-1:0] RATIO_MAX = {RATIO_W{1'b1}};
    localparam logic [RATIO_W-1:0] RATIO_ONE = RATIO_W'(1) << RATIO_FRAC_BITS;

    localparam int AXIS_W = 16;
    localparam int MAG_W  = AXIS_W + 1;
    localparam int DIAG_W = 7;
    localparam int SQ_W   = 2 * AXIS_W;
    localparam int DM_W   = MAG_W + DIAG_W;
    localparam int CMP_W  = 48;

    // Square root of the sum of squares carried as Q16.8.
    localparam int SQ_FRAC_SHIFT        = 16;
    localparam int SQRT_OP_W            = SQ_W + SQ_FRAC_SHIFT;
    localparam int RQ_W                 = SQRT_OP_W / 2;
    localparam int SQRT_REM_W           = RQ_W + 2;
    localparam int SQRT_STEPS_PER_STAGE = 3;
    localparam int SQRT_STAGES          = RQ_W / SQRT_STEPS_PER_STAGE;

    // 50 * sqrt(2) in Q30, the numerator of the corner ratio.
    localparam int CNUM_W = 37;
    localparam int CLO_W  = 19;
    localparam logic [CNUM_W-1:0] CIRCLE_NUM = 37'd75925012500;
    localparam logic [13:0] NEAR_SCALE = 14'd10000;

    localparam int NUM_W           = RQ_W + CNUM_W;
    localparam int SQ_DEN_SHIFT    = 38 - RATIO_FRAC_BITS;
    localparam int CI_DEN_SHIFT    = 30 - RATIO_FRAC_BITS;
    localparam int DEN_W           = DM_W + SQ_DEN_SHIFT;
    localparam int DIV_STEPS_PER_STAGE = 2;
    localparam int DIV_STAGES      = (RATIO_W + DIV_STEPS_PER_STAGE - 1) / DIV_STEPS_PER_STAGE;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_DIAGONAL    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SQUARE_MODE = 1'd1;
    localparam logic [DIAG_W-1:0]    DIAG_RESET      = 7'd100;

    typedef struct packed {
        logic signed [AXIS_W-1:0] x_in;
        logic signed [AXIS_W-1:0] y_in;
    } in_word_t;

    typedef struct packed {
        logic signed [AXIS_W-1:0] x_out;
        logic signed [AXIS_W-1:0] y_out;
    } out_word_t;

    // Pipeline advance and the valid bit entering a unit.
    typedef struct packed {
        logic en;
        logic valid;
    } pipe_ctl_t;

    typedef struct packed {
        in_word_t          xy;
        logic [MAG_W-1:0]  m;
        logic [DM_W-1:0]   dm;
        logic [DIAG_W-1:0] d;
        logic              sq_mode;
        logic              near;
        logic              zero;
    } side_t;

endpackage

FILE: rtl/sscr_front.sv
// Front stages of the remapper: magnitudes, sum of squares and the exact corner test.
// Depends on sscr_pkg.
module sscr_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  sscr_pkg::pipe_ctl_t           ctl,
    input  sscr_pkg::in_word_t            in_data,
    input  logic [sscr_pkg::DIAG_W-1:0]   diag,
    input  logic                          sq_mode,
    output logic                          valid,
    output logic [sscr_pkg::SQ_W-1:0]     sq,
    output sscr_pkg::side_t               side
);
    import sscr_pkg::*;

    logic signed [MAG_W-1:0] xs, ys;
    logic [MAG_W-1:0]        ax_next, ay_next;
    logic [2*MAG_W-1:0]      ax2, ay2;
    side_t                   s1_next;
    side_t                   s2_side_next;
    side_t                   s4_side_next;

    logic              s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic [MAG_W-1:0]  s1_ax_reg, s1_ay_reg;
    side_t             s1_side_reg, s2_side_reg, s3_side_reg, s4_side_reg;
    logic [SQ_W-1:0]   s2_sq_reg, s3_sq_reg, s4_sq_reg;
    logic [CMP_W-1:0]  s3_dm2_reg, s3_sq10k_reg;

    assign xs      = MAG_W'(in_data.x_in);
    assign ys      = MAG_W'(in_data.y_in);
    assign ax_next = xs[MAG_W-1] ? MAG_W'(-xs) : MAG_W'(xs);
    assign ay_next = ys[MAG_W-1] ? MAG_W'(-ys) : MAG_W'(ys);

    always_comb
    begin
        s1_next         = '0;
        s1_next.xy      = in_data;
        s1_next.m       = (ax_next > ay_next) ? ax_next : ay_next;
        s1_next.d       = diag;
        s1_next.sq_mode = sq_mode;
    end

    assign ax2 = (2*MAG_W)'(s1_ax_reg) * (2*MAG_W)'(s1_ax_reg);
    assign ay2 = (2*MAG_W)'(s1_ay_reg) * (2*MAG_W)'(s1_ay_reg);

    always_comb
    begin
        s2_side_next    = s1_side_reg;
        s2_side_next.dm = DM_W'(s1_side_reg.m) * DM_W'(s1_side_reg.d);
    end

    // Corner test 2*d*d*m*m < 10000*S, exact.
    always_comb
    begin
        s4_side_next      = s3_side_reg;
        s4_side_next.near = {s3_dm2_reg[CMP_W-2:0], 1'b0} < s3_sq10k_reg;
        s4_side_next.zero = (s3_side_reg.m == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else if (ctl.en)
        begin
            s1_valid_reg <= ctl.valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            s1_ax_reg   <= ax_next;
            s1_ay_reg   <= ay_next;
            s1_side_reg <= s1_next;

            s2_sq_reg   <= SQ_W'(ax2 + ay2);
            s2_side_reg <= s2_side_next;

            s3_sq_reg    <= s2_sq_reg;
            s3_side_reg  <= s2_side_reg;
            s3_dm2_reg   <= CMP_W'(s2_side_reg.dm) * CMP_W'(s2_side_reg.dm);
            s3_sq10k_reg <= CMP_W'(s2_sq_reg) * CMP_W'(NEAR_SCALE);

            s4_sq_reg   <= s3_sq_reg;
            s4_side_reg <= s4_side_next;
        end
    end

    assign valid = s4_valid_reg;
    assign sq    = s4_sq_reg;
    assign side  = s4_side_reg;

    a_near_not_origin: assert property (@(posedge clk) disable iff (!rst_n)
        s4_valid_reg && s4_side_reg.near |-> !s4_side_reg.zero)
        else $error("corner flag set for the origin");

endmodule

FILE: rtl/sscr_isqrt.sv
// Pipelined integer square root of the sum of squares scaled by 2^16.
// Depends on sscr_pkg.
module sscr_isqrt (
    input  logic                          clk,
    input  logic                          rst_n,
    input  sscr_pkg::pipe_ctl_t           ctl,
    input  logic [sscr_pkg::SQ_W-1:0]     sq,
    input  sscr_pkg::side_t               side_in,
    output logic                          valid,
    output logic [sscr_pkg::RQ_W-1:0]     root,
    output sscr_pkg::side_t               side_out
);
    import sscr_pkg::*;

    logic                  valid_reg [SQRT_STAGES];
    logic [SQRT_OP_W-1:0]  op_reg    [SQRT_STAGES];
    logic [SQRT_REM_W-1:0] rem_reg   [SQRT_STAGES];
    logic [RQ_W-1:0]       root_reg  [SQRT_STAGES];
    side_t                 side_reg  [SQRT_STAGES];

    for (genvar k = 0; k < SQRT_STAGES; k++)
    begin : g_stage
        logic                  v_in;
        logic [SQRT_OP_W-1:0]  op_in, op_next;
        logic [SQRT_REM_W-1:0] rem_in, rem_next;
        logic [RQ_W-1:0]       root_in, root_next;
        side_t                 sd_in;

        if (k == 0)
        begin : g_first
            assign v_in    = ctl.valid;
            assign op_in   = SQRT_OP_W'(sq) << SQ_FRAC_SHIFT;
            assign rem_in  = '0;
            assign root_in = '0;
            assign sd_in   = side_in;
        end
        else
        begin : g_rest
            assign v_in    = valid_reg[k-1];
            assign op_in   = op_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign sd_in   = side_reg[k-1];
        end

        // One result bit per step, two operand bits brought down each time.
        always_comb
        begin
            logic [SQRT_REM_W-1:0] rem_sh, trial;
            op_next   = op_in;
            rem_next  = rem_in;
            root_next = root_in;
            for (int j = 0; j < SQRT_STEPS_PER_STAGE; j++)
            begin
                rem_sh = {rem_next[SQRT_REM_W-3:0], op_next[SQRT_OP_W-1 -: 2]};
                trial  = {root_next, 2'b01};
                if (rem_sh >= trial)
                begin
                    rem_next  = rem_sh - trial;
                    root_next = {root_next[RQ_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = rem_sh;
                    root_next = {root_next[RQ_W-2:0], 1'b0};
                end
                op_next = {op_next[SQRT_OP_W-3:0], 2'b00};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[k] <= 1'b0;
            else if (ctl.en)
                valid_reg[k] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            if (ctl.en)
            begin
                op_reg[k]   <= op_next;
                rem_reg[k]  <= rem_next;
                root_reg[k] <= root_next;
                side_reg[k] <= sd_in;
            end
        end
    end

    assign valid    = valid_reg[SQRT_STAGES-1];
    assign root     = root_reg[SQRT_STAGES-1];
    assign side_out = side_reg[SQRT_STAGES-1];

endmodule

FILE: rtl/sscr_div.sv
// Ratio unit: picks numerator and denominator for the mode, then a pipelined
// restoring divider with saturation. Depends on sscr_pkg.
module sscr_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  sscr_pkg::pipe_ctl_t           ctl,
    input  logic [sscr_pkg::RQ_W-1:0]     root,
    input  sscr_pkg::side_t               side_in,
    output logic                          valid,
    output logic [sscr_pkg::RATIO_W-1:0]  ratio,
    output sscr_pkg::in_word_t            xy
);
    import sscr_pkg::*;

    localparam int PH_W = RQ_W + CNUM_W - CLO_W;
    localparam int PL_W = RQ_W + CLO_W;
    localparam int HI_W = NUM_W - RATIO_W;
    localparam logic [CNUM_W-CLO_W-1:0] C_HI = CIRCLE_NUM[CNUM_W-1:CLO_W];
    localparam logic [CLO_W-1:0]        C_LO = CIRCLE_NUM[CLO_W-1:0];

    typedef struct packed {
        logic [DEN_W-1:0]   rem;
        logic [RATIO_W-1:0] low;
        logic [RATIO_W-1:0] q;
        logic [DEN_W-1:0]   den;
        logic               ovf;
        logic               ovr;
        logic [RATIO_W-1:0] ovr_val;
        in_word_t           xy;
    } div_st_t;

    logic             p1_valid_reg, p2_valid_reg;
    logic [PH_W-1:0]  p1_hi_reg;
    logic [PL_W-1:0]  p1_lo_reg;
    logic [RQ_W-1:0]  p1_root_reg;
    side_t            p1_side_reg;

    logic [NUM_W-1:0]   p2_num_reg, num_next;
    logic [DEN_W-1:0]   p2_den_reg, den_next;
    logic               p2_ovr_reg, ovr_next;
    logic [RATIO_W-1:0] p2_ovr_val_reg, ovr_val_next;
    in_word_t           p2_xy_reg;

    logic               st_valid_reg [DIV_STAGES+1];
    div_st_t            st_reg       [DIV_STAGES+1];
    logic [HI_W-1:0]    num_hi;
    div_st_t            st0_next;

    // Numerator and denominator for each mode and side of the corner test, or an override ratio.
    always_comb
    begin
        num_next     = '0;
        den_next     = DEN_W'(1);
        ovr_next     = 1'b0;
        ovr_val_next = RATIO_MAX;
        if (p1_side_reg.zero)
        begin
            ovr_next = 1'b1;
        end
        else if (p1_side_reg.near)
        begin
            if (p1_side_reg.d == '0)
                ovr_next = 1'b1;
            else if (p1_side_reg.sq_mode)
            begin
                num_next = (NUM_W'(p1_hi_reg) << CLO_W) + NUM_W'(p1_lo_reg);
                den_next = DEN_W'(p1_side_reg.dm) << SQ_DEN_SHIFT;
            end
            else
            begin
                num_next = NUM_W'(CIRCLE_NUM);
                den_next = DEN_W'(p1_side_reg.d) << CI_DEN_SHIFT;
            end
        end
        else if (p1_side_reg.sq_mode)
        begin
            ovr_next     = 1'b1;
            ovr_val_next = RATIO_ONE;
        end
        else
        begin
            num_next = NUM_W'(p1_side_reg.m) << RATIO_W;
            den_next = DEN_W'(p1_root_reg);
        end
    end

    assign num_hi = p2_num_reg[NUM_W-1:RATIO_W];

    always_comb
    begin
        st0_next         = '0;
        st0_next.den     = p2_den_reg;
        st0_next.ovf     = DEN_W'(num_hi) >= p2_den_reg;
        st0_next.rem     = DEN_W'(num_hi);
        st0_next.low     = p2_num_reg[RATIO_W-1:0];
        st0_next.ovr     = p2_ovr_reg;
        st0_next.ovr_val = p2_ovr_val_reg;
        st0_next.xy      = p2_xy_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg    <= 1'b0;
            p2_valid_reg    <= 1'b0;
            st_valid_reg[0] <= 1'b0;
        end
        else if (ctl.en)
        begin
            p1_valid_reg    <= ctl.valid;
            p2_valid_reg    <= p1_valid_reg;
            st_valid_reg[0] <= p2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            p1_hi_reg      <= PH_W'(root) * PH_W'(C_HI);
            p1_lo_reg      <= PL_W'(root) * PL_W'(C_LO);
            p1_root_reg    <= root;
            p1_side_reg    <= side_in;
            p2_num_reg     <= num_next;
            p2_den_reg     <= den_next;
            p2_ovr_reg     <= ovr_next;
            p2_ovr_val_reg <= ovr_val_next;
            p2_xy_reg      <= p1_side_reg.xy;
            st_reg[0]      <= st0_next;
        end
    end

    for (genvar k = 1; k <= DIV_STAGES; k++)
    begin : g_stage
        div_st_t st_next;

        always_comb
        begin
            logic [DEN_W:0] rem_sh;
            st_next = st_reg[k-1];
            for (int j = 0; j < DIV_STEPS_PER_STAGE; j++)
            begin
                if ((k - 1) * DIV_STEPS_PER_STAGE + j < RATIO_W)
                begin
                    rem_sh      = {st_next.rem, st_next.low[RATIO_W-1]};
                    st_next.low = {st_next.low[RATIO_W-2:0], 1'b0};
                    if (rem_sh >= {1'b0, st_next.den})
                    begin
                        st_next.rem = DEN_W'(rem_sh - {1'b0, st_next.den});
                        st_next.q   = {st_next.q[RATIO_W-2:0], 1'b1};
                    end
                    else
                    begin
                        st_next.rem = rem_sh[DEN_W-1:0];
                        st_next.q   = {st_next.q[RATIO_W-2:0], 1'b0};
                    end
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                st_valid_reg[k] <= 1'b0;
            else if (ctl.en)
                st_valid_reg[k] <= st_valid_reg[k-1];
        end

        always_ff @(posedge clk)
        begin
            if (ctl.en)
                st_reg[k] <= st_next;
        end
    end

    assign valid = st_valid_reg[DIV_STAGES];
    assign ratio = st_reg[DIV_STAGES].ovr ? st_reg[DIV_STAGES].ovr_val :
                   (st_reg[DIV_STAGES].ovf ? RATIO_MAX : st_reg[DIV_STAGES].q);
    assign xy    = st_reg[DIV_STAGES].xy;

endmodule

FILE: rtl/sscr_scale.sv
// Output stages: multiplies each axis by the ratio, floors and saturates.
// Depends on sscr_pkg.
module sscr_scale (
    input  logic                          clk,
    input  logic                          rst_n,
    input  sscr_pkg::pipe_ctl_t           ctl,
    input  logic [sscr_pkg::RATIO_W-1:0]  ratio,
    input  sscr_pkg::in_word_t            xy,
    output logic                          valid,
    output sscr_pkg::out_word_t           data
);
    import sscr_pkg::*;

    localparam int PROD_W = MAG_W + RATIO_W;
    localparam logic [PROD_W:0] ROUND_UP = (PROD_W+1)'((1 << RATIO_FRAC_BITS) - 1);
    localparam logic [PROD_W:0] POS_MAX  = (PROD_W+1)'(32767);
    localparam logic [PROD_W:0] NEG_MAX  = (PROD_W+1)'(32768);

    // Floor of a signed product: a negative value rounds its magnitude up.
    function automatic logic [AXIS_W-1:0] floor_sat(input logic neg, input logic [PROD_W-1:0] p);
        logic [PROD_W:0] q;
        logic [PROD_W:0] neg_q;
        logic [AXIS_W-1:0] res;
        if (!neg)
        begin
            q   = (PROD_W+1)'(p) >> RATIO_FRAC_BITS;
            res = (q > POS_MAX) ? AXIS_W'(32767) : q[AXIS_W-1:0];
        end
        else
        begin
            q     = ((PROD_W+1)'(p) + ROUND_UP) >> RATIO_FRAC_BITS;
            neg_q = -q;
            res   = (q > NEG_MAX) ? AXIS_W'(32768) : neg_q[AXIS_W-1:0];
        end
        return res;
    endfunction

    logic signed [MAG_W-1:0] xs, ys;
    logic [MAG_W-1:0]        ax, ay;

    logic              a_valid_reg, out_valid_reg;
    logic              a_xneg_reg, a_yneg_reg;
    logic [PROD_W-1:0] a_px_reg, a_py_reg;
    out_word_t         out_data_reg;

    assign xs = MAG_W'(xy.x_in);
    assign ys = MAG_W'(xy.y_in);
    assign ax = xs[MAG_W-1] ? MAG_W'(-xs) : MAG_W'(xs);
    assign ay = ys[MAG_W-1] ? MAG_W'(-ys) : MAG_W'(ys);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (ctl.en)
        begin
            a_valid_reg   <= ctl.valid;
            out_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            a_xneg_reg         <= xs[MAG_W-1];
            a_yneg_reg         <= ys[MAG_W-1];
            a_px_reg           <= PROD_W'(ax) * PROD_W'(ratio);
            a_py_reg           <= PROD_W'(ay) * PROD_W'(ratio);
            out_data_reg.x_out <= floor_sat(a_xneg_reg, a_px_reg);
            out_data_reg.y_out <= floor_sat(a_yneg_reg, a_py_reg);
        end
    end

    assign valid = out_valid_reg;
    assign data  = out_data_reg;

endmodule

FILE: rtl/stick_square_circle_remap.sv
// Top level of the stick square/circle remapper.
// Depends on sscr_pkg, sscr_front, sscr_isqrt, sscr_div and sscr_scale.
//
// Takes one signed 16-bit stick sample per word and returns it rescaled along
// its own direction, so that a square or rounded-box pad range maps onto a
// circle (square mode 0) or a circle onto a square (square mode 1);
// the diagonal register gives the pad's observed diagonal reach. Every input word
// yields exactly one output word, and the origin always maps to the origin.
// The block accepts one word in every clock cycle unless the pipeline holds,
// and each word passes four front stages for magnitudes, the sum of squares and
// the exact corner test, eight square-root stages of three result bits each,
// fifteen ratio stages (operand selection and a restoring divider of two
// quotient bits per stage) and two stages of multiply, floor and saturation.
// The whole pipeline advances together; it holds only while a finished word
// waits at the output and stall is high, and in_stall then follows. Write the
// configuration registers only while no word is in flight.
module stick_square_circle_remap (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  sscr_pkg::in_word_t              in_data,
    output logic                            out_valid,
    input  logic                            out_stall,
    output sscr_pkg::out_word_t             out_data,
    input  logic                            cfg_we,
    input  logic [sscr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sscr_pkg::DIAG_W-1:0]     cfg_data
);
    import sscr_pkg::*;

    logic [DIAG_W-1:0] diag_reg;
    logic              mode_reg;
    logic              advance;

    logic               front_valid, sqrt_valid, div_valid;
    logic [SQ_W-1:0]    front_sq;
    side_t              front_side, sqrt_side;
    logic [RQ_W-1:0]    sqrt_root;
    logic [RATIO_W-1:0] div_ratio;
    in_word_t           div_xy;

    // The pipeline moves whenever the output register is empty or being taken.
    assign advance  = !out_valid || !out_stall;
    assign in_stall = !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            diag_reg <= DIAG_RESET;
            mode_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_DIAGONAL:    diag_reg <= cfg_data;
                REG_SQUARE_MODE: mode_reg <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    sscr_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     ('{en: advance, valid: in_valid}),
        .in_data (in_data),
        .diag    (diag_reg),
        .sq_mode (mode_reg),
        .valid   (front_valid),
        .sq      (front_sq),
        .side    (front_side)
    );

    sscr_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      ('{en: advance, valid: front_valid}),
        .sq       (front_sq),
        .side_in  (front_side),
        .valid    (sqrt_valid),
        .root     (sqrt_root),
        .side_out (sqrt_side)
    );

    sscr_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     ('{en: advance, valid: sqrt_valid}),
        .root    (sqrt_root),
        .side_in (sqrt_side),
        .valid   (div_valid),
        .ratio   (div_ratio),
        .xy      (div_xy)
    );

    sscr_scale u_scale (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   ('{en: advance, valid: div_valid}),
        .ratio (div_ratio),
        .xy    (div_xy),
        .valid (out_valid),
        .data  (out_data)
    );

    a_stall_from_output: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled while the output is free");

    a_take_frees_input: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall) |-> !in_stall)
        else $error("input stalled while an output word is taken");

    a_mode_held: assert property (@(posedge clk) disable iff (!rst_n)
        !cfg_we |=> $stable(mode_reg) && $stable(diag_reg))
        else $error("configuration changed without a write");

endmodule

FILE: sim/tb_top.sv
// Self-checking testbench for the stick square/circle remapper.
// Depends on sscr_pkg and stick_square_circle_remap; drives random and directed words.
module tb_top;
    import sscr_pkg::*;

    localparam int LATENCY     = 29;
    localparam int IDLE_LIMIT  = 2000;
    localparam int RANDOM_WORDS = 1550;
    localparam longint unsigned SQRT2_Q30 = 64'd1518500250;
    localparam int FRAC = 16;
    localparam longint unsigned RMAX = (64'd1 << (FRAC + 8)) - 64'd1;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    in_word_t             in_data;
    logic                 out_valid;
    logic                 out_stall;
    out_word_t            out_data;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [DIAG_W-1:0]    cfg_data;

    // Words waiting to be sent, and the remapped words we expect back.
    in_word_t  send_q[$];
    int        send_gap_q[$];
    out_word_t remap_q[$];

    // Shadow copies of the configuration registers.
    logic [DIAG_W-1:0] diag_pct;
    logic              square_mode;

    int  errors;
    int  idle_cycles;
    int  gap_left;
    int  stall_left;

    // Periods with no idling on either side.
    bit stretch_calm;

    stick_square_circle_remap u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Bitwise integer square root of a 64-bit value.
    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > n)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (n >= res + bitv)
            begin
                n   = n - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv >>= 2;
        end
        return res;
    endfunction

    // Multiplies one axis by the ratio, floors towards minus infinity and saturates.
    function automatic logic signed [15:0] scale_axis_by(int v, longint unsigned ratio);
        longint q;
        longint unsigned mag;
        longint unsigned p;
        if (v >= 0)
        begin
            mag = longint'(v);
            q   = longint'((mag * ratio) >> FRAC);
        end
        else
        begin
            mag = longint'(-v);
            p   = mag * ratio;
            q   = -longint'((p + ((64'd1 << FRAC) - 1)) >> FRAC);
        end
        if (q > 32767)
            q = 32767;
        if (q < -32768)
            q = -32768;
        return q[15:0];
    endfunction

    // Works out the remapped word for one stick sample under the current settings.
    function automatic out_word_t remap_sample(in_word_t w);
        out_word_t       r;
        int              x;
        int              y;
        longint unsigned ax;
        longint unsigned ay;
        longint unsigned m;
        longint unsigned d;
        longint unsigned sq;
        longint unsigned rq;
        longint unsigned ratio;
        bit              beyond_corner;
        x  = int'(w.x_in);
        y  = int'(w.y_in);
        ax = longint'((x < 0) ? -x : x);
        ay = longint'((y < 0) ? -y : y);
        m  = (ax > ay) ? ax : ay;
        d  = 64'(diag_pct);
        if (m == 0)
        begin
            r = '0;
            return r;
        end
        sq = ax * ax + ay * ay;
        rq = int_sqrt(sq << 16);
        // The corner test is exact and does not use the truncated root.
        beyond_corner = (2 * d * d * m * m) < (64'd10000 * sq);
        if (beyond_corner)
        begin
            if (d == 0)
                ratio = RMAX;
            else if (square_mode)
                ratio = (rq * 50 * SQRT2_Q30) / ((m * d) << (38 - FRAC));
            else
                ratio = (50 * SQRT2_Q30) / (d << (30 - FRAC));
        end
        else if (square_mode)
            ratio = 64'd1 << FRAC;
        else
            ratio = (m << (FRAC + 8)) / rq;
        if (ratio > RMAX)
            ratio = RMAX;
        r.x_out = scale_axis_by(x, ratio);
        r.y_out = scale_axis_by(y, ratio);
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch on %s: got %0d, expected %0d", what, got, want);
        errors++;
    endtask

    // Driver: presents queued words with a random gap before each one.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
            gap_left <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                remap_q.push_back(remap_sample(in_data));
            end
            if (!in_valid || !in_stall)
            begin
                if (gap_left > 0)
                begin
                    in_valid <= 1'b0;
                    gap_left <= gap_left - 1;
                end
                else if (send_q.size() > 0 && send_gap_q[0] > 0)
                begin
                    // Take the gap drawn for the next word before presenting it.
                    in_valid <= 1'b0;
                    gap_left <= send_gap_q[0] - 1;
                    send_gap_q[0] = 0;
                end
                else if (send_q.size() > 0)
                begin
                    in_valid <= 1'b1;
                    in_data  <= send_q.pop_front();
                    void'(send_gap_q.pop_front());
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Monitor: checks each accepted word and draws the receiver's stall.
    always @(posedge clk or negedge rst_n)
    begin
        out_word_t want;
        if (!rst_n)
        begin
            out_stall   <= 1'b0;
            stall_left  <= 0;
            idle_cycles <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (remap_q.size() == 0)
                begin
                    $display("unexpected word x=%0d y=%0d", out_data.x_out, out_data.y_out);
                    errors++;
                end
                else
                begin
                    want = remap_q.pop_front();
                    if (out_data.x_out !== want.x_out)
                        report_mismatch("x_out", out_data.x_out, want.x_out);
                    if (out_data.y_out !== want.y_out)
                        report_mismatch("y_out", out_data.y_out, want.y_out);
                end
            end
            // A stall run of random length is drawn after each accepted word.
            if (stall_left > 0)
            begin
                out_stall  <= 1'b1;
                stall_left <= stall_left - 1;
            end
            else if (out_valid && !out_stall)
            begin
                stall_left <= (stretch_calm) ? 0 : $urandom_range(0, 5);
                out_stall  <= 1'b0;
            end
            else
                out_stall <= 1'b0;
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    always @(posedge clk)
    begin
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic queue_word(logic signed [15:0] x, logic signed [15:0] y);
        in_word_t w;
        w.x_in = x;
        w.y_in = y;
        send_q.push_back(w);
        send_gap_q.push_back(stretch_calm ? 0 : $urandom_range(0, 5));
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DIAG_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_DIAGONAL)
            diag_pct = value;
        else
            square_mode = value[0];
    endtask

    // Waits until every queued word is sent and answered, then lets the pipe drain.
    task automatic drain;
        while (send_q.size() > 0 || in_valid || remap_q.size() > 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic random_word;
        int kind;
        logic signed [15:0] a;
        logic signed [15:0] b;
        kind = $urandom_range(0, 9);
        a = 16'($urandom);
        b = 16'($urandom);
        case (kind)
            0: queue_word(a, 16'sd0);
            1: queue_word(16'sd0, b);
            2: queue_word(a, a);
            3: queue_word(a, -a);
            4: queue_word(16'($urandom_range(0, 15)) - 16'd8,
                          16'($urandom_range(0, 15)) - 16'd8);
            default: queue_word(a, b);
        endcase
    endtask

    // One phase: set both registers, send directed and random words, drain.
    task automatic run_phase(logic [DIAG_W-1:0] d, logic mode, int count);
        write_reg(REG_DIAGONAL, d);
        write_reg(REG_SQUARE_MODE, DIAG_W'(mode));
        queue_word(16'sd0, 16'sd0);
        queue_word(16'sh7fff, 16'sh7fff);
        queue_word(-16'sh8000, -16'sh8000);
        queue_word(-16'sh8000, 16'sh7fff);
        queue_word(16'sh7fff, 16'sd0);
        queue_word(16'sd0, -16'sh8000);
        queue_word(16'sd1, 16'sd1);
        queue_word(-16'sd1, 16'sd0);
        queue_word(16'sd1000, 16'sd999);
        for (int i = 0; i < count; i++)
        begin
            stretch_calm = (i % 200) >= 160;
            random_word();
        end
        stretch_calm = 1'b0;
        drain();
    endtask

    initial
    begin
        errors       = 0;
        stretch_calm = 1'b0;
        diag_pct     = DIAG_RESET;
        square_mode  = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        rst_n        = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        // Reset values first, then a sweep over diagonals and both modes.
        for (int i = 0; i < 12; i++)
            random_word();
        drain();
        run_phase(7'd100, 1'b1, 250);
        run_phase(7'd1, 1'b0, 200);
        run_phase(7'd1, 1'b1, 200);
        run_phase(7'd0, 1'b0, 100);
        run_phase(7'd0, 1'b1, 100);
        run_phase(7'd127, 1'b0, 150);
        run_phase(7'd127, 1'b1, 150);
        run_phase(7'($urandom_range(60, 99)), 1'b0, 200);
        run_phase(7'($urandom_range(60, 99)), 1'b1, 200);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

FILE: files.f
rtl/sscr_pkg.sv
rtl/sscr_front.sv
rtl/sscr_isqrt.sv
rtl/sscr_div.sv
rtl/sscr_scale.sv
rtl/stick_square_circle_remap.sv
sim/tb_top.sv
